### rtl/v3au_pkg.sv
// ----------------------------------------------------------------------------
// v3au_pkg
// shared types, op codes and register indexes of the vector arithmetic unit
// ----------------------------------------------------------------------------
package v3au_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int THRESH_WIDTH   = 31;
	localparam int CFG_ADDR_WIDTH = 3;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_DOT   = 3'd2,
		OP_CROSS = 3'd3,
		OP_SCALE = 3'd4,
		OP_MAG   = 3'd5,
		OP_UNIT  = 3'd6,
		OP_NONE  = 3'd7
	} op_t;

	localparam logic [CFG_ADDR_WIDTH-1:0] REG_NULL_THRESHOLD = 3'd0;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] scale_factor;
	} item_in_t;

	typedef struct packed {
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic signed [31:0] scalar_out;
		logic               is_null;
		logic               overflow;
	} item_out_t;

	// saturate a 66 bit signed value to 32 bits
	function automatic logic [32:0] sat32(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > 66'sh7FFFFFFF)
			r = {1'b1, 32'h7FFFFFFF};
		else if (v < -66'sh80000000)
			r = {1'b1, 32'h80000000};
		else
			r = {1'b0, v[31:0]};
		return r;
	endfunction

endpackage

### rtl/vector3_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit
// three component Q16.16 vector arithmetic: add, subtract, dot, cross,
// scale, magnitude and unit vector, in one fixed-latency pipeline
// ----------------------------------------------------------------------------
//  channel   | signals                               | handshake
//  ----------+---------------------------------------+---------------------
//  item in   | start, busy, in_item                  | start & !busy
//  item out  | done, out_item                        | done, one cycle
//  config    | psel penable pwrite paddr pwdata ...  | apb, pready high
//
//  one item is taken every cycle; busy is tied low
//  every item takes the same latency: it passes the products and sums,
//  the square root, the division and the output register; the divider
//  sets most of it
//  all ops go through the whole pipeline so results leave in order
//  reset clears the valid bits and the threshold register only
//  the receiver cannot stall, so there is no back pressure anywhere
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit #(
	parameter int FRAC_BITS  = v3au_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  v3au_pkg::item_in_t                      in_item,
	output logic                                    done,
	output v3au_pkg::item_out_t                     out_item,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [v3au_pkg::CFG_ADDR_WIDTH-1:0]     paddr,
	input  logic [31:0]                             pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready
);
	// word width is fixed by the item structs and the saturation helper
	localparam int DATA_WIDTH = v3au_pkg::DATA_WIDTH_DEF;
	// products are 2*DATA_WIDTH, sums of three need two more bits
	localparam int PW = 2 * DATA_WIDTH + 2;
	localparam int NW = DATA_WIDTH + FRAC_BITS;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// ---- configuration ----
	logic [v3au_pkg::THRESH_WIDTH-1:0] thresh_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thresh_q <= '0;
		else if (psel && penable && pwrite && paddr == v3au_pkg::REG_NULL_THRESHOLD)
			thresh_q <= pwdata[v3au_pkg::THRESH_WIDTH-1:0];
	end
	assign prdata = (paddr == v3au_pkg::REG_NULL_THRESHOLD) ? {1'b0, thresh_q} : '0;

	// ---- stage 1: all products ----
	logic                 vld_s1;
	v3au_pkg::op_t        op_s1;
	logic signed [DATA_WIDTH-1:0] ax_s1, ay_s1, az_s1;
	logic signed [PW-1:0] p_s1 [12];
	logic signed [DATA_WIDTH-1:0] ia [3], ib [3];
	logic signed [DATA_WIDTH-1:0] isf;

	always_comb begin
		ia[0] = DATA_WIDTH'(in_item.a_x);
		ia[1] = DATA_WIDTH'(in_item.a_y);
		ia[2] = DATA_WIDTH'(in_item.a_z);
		ib[0] = DATA_WIDTH'(in_item.b_x);
		ib[1] = DATA_WIDTH'(in_item.b_y);
		ib[2] = DATA_WIDTH'(in_item.b_z);
		isf   = DATA_WIDTH'(in_item.scale_factor);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		op_s1 <= v3au_pkg::op_t'(in_item.op);
		ax_s1 <= ia[0];
		ay_s1 <= ia[1];
		az_s1 <= ia[2];
		// a_i*b_i (dot), a_i*a_i (magnitude), s*a_i (scale)
		for (int i = 0; i < 3; i++) begin
			p_s1[i]     <= PW'(ia[i] * ib[i]);
			p_s1[3 + i] <= PW'(ia[i] * ia[i]);
			p_s1[6 + i] <= PW'(isf * ia[i]);
		end
		// cross terms a1b2 - b1a2 etc: both products and their difference are formed here
		p_s1[9]  <= PW'(ia[1] * ib[2]) - PW'(ib[1] * ia[2]);
		p_s1[10] <= PW'(ia[2] * ib[0]) - PW'(ib[2] * ia[0]);
		p_s1[11] <= PW'(ia[0] * ib[1]) - PW'(ib[0] * ia[1]);
	end

	// ---- stage 2: sums, shifts, saturation for non-iterative ops ----
	typedef struct packed {
		v3au_pkg::op_t         op;
		logic signed [NW-1:0]  nx;
		logic signed [NW-1:0]  ny;
		logic signed [NW-1:0]  nz;
		logic [31:0]           rx;
		logic [31:0]           ry;
		logic [31:0]           rz;
		logic [31:0]           sc;
		logic                  ov;
	} carry_t;

	logic                 vld_s2;
	carry_t               cr_s2;
	logic [PW-1:0]        sq_s2;
	logic signed [PW-1:0] dot, cx, cy, cz;
	logic [32:0]          sx, sy, sz, ss;
	carry_t               cr_n;

	// add and subtract are done here from the registered a and registered
	// b: b is kept in its own registers rather than recovered from products
	logic signed [DATA_WIDTH-1:0] bx_s1, by_s1, bz_s1;
	always_ff @(posedge clk) begin
		bx_s1 <= ib[0];
		by_s1 <= ib[1];
		bz_s1 <= ib[2];
	end

	always_comb begin
		dot = (p_s1[0] + p_s1[1] + p_s1[2]) >>> FRAC_BITS;
		cx  = p_s1[9]  >>> FRAC_BITS;
		cy  = p_s1[10] >>> FRAC_BITS;
		cz  = p_s1[11] >>> FRAC_BITS;
		cr_n = '0;
		cr_n.op = op_s1;
		cr_n.nx = NW'(ax_s1) <<< FRAC_BITS;
		cr_n.ny = NW'(ay_s1) <<< FRAC_BITS;
		cr_n.nz = NW'(az_s1) <<< FRAC_BITS;
		sx = '0; sy = '0; sz = '0; ss = '0;
		case (op_s1)
			v3au_pkg::OP_ADD: begin
				sx = v3au_pkg::sat32(66'(ax_s1) + 66'(bx_s1));
				sy = v3au_pkg::sat32(66'(ay_s1) + 66'(by_s1));
				sz = v3au_pkg::sat32(66'(az_s1) + 66'(bz_s1));
			end
			v3au_pkg::OP_SUB: begin
				sx = v3au_pkg::sat32(66'(ax_s1) - 66'(bx_s1));
				sy = v3au_pkg::sat32(66'(ay_s1) - 66'(by_s1));
				sz = v3au_pkg::sat32(66'(az_s1) - 66'(bz_s1));
			end
			v3au_pkg::OP_DOT:   ss = v3au_pkg::sat32(66'(dot));
			v3au_pkg::OP_CROSS: begin
				sx = v3au_pkg::sat32(66'(cx));
				sy = v3au_pkg::sat32(66'(cy));
				sz = v3au_pkg::sat32(66'(cz));
			end
			v3au_pkg::OP_SCALE: begin
				sx = v3au_pkg::sat32(66'(p_s1[6] >>> FRAC_BITS));
				sy = v3au_pkg::sat32(66'(p_s1[7] >>> FRAC_BITS));
				sz = v3au_pkg::sat32(66'(p_s1[8] >>> FRAC_BITS));
			end
			default: ;
		endcase
		cr_n.rx = sx[31:0];
		cr_n.ry = sy[31:0];
		cr_n.rz = sz[31:0];
		cr_n.sc = ss[31:0];
		cr_n.ov = sx[32] | sy[32] | sz[32] | ss[32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		cr_s2 <= cr_n;
		sq_s2 <= PW'(p_s1[3] + p_s1[4] + p_s1[5]);
	end

	// ---- square root ----
	logic                 vld_sq;
	logic [PW/2-1:0]      mag_sq;
	carry_t               cr_sq;

	v3au_sqrt #(.IN_W(PW), .tag_t(carry_t)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s2),
		.in_rad   (sq_s2),
		.in_tag   (cr_s2),
		.out_vld  (vld_sq),
		.out_root (mag_sq),
		.out_tag  (cr_sq)
	);

	// null test and scalar magnitude, carried along the divider
	typedef struct packed {
		carry_t      cr;
		logic        nul;
	} dtag_t;

	dtag_t dt_in, dx_t, dy_t, dz_t;
	logic [32:0] msat;
	logic [PW/2-1:0] den;
	always_comb begin
		dt_in.cr  = cr_sq;
		dt_in.nul = mag_sq <= (PW/2)'(thresh_q);
		msat = v3au_pkg::sat32(66'($signed({1'b0, mag_sq})));
		if (cr_sq.op == v3au_pkg::OP_MAG) begin
			dt_in.cr.sc = msat[31:0];
			dt_in.cr.ov = msat[32];
		end
		// a zero divisor only occurs for null vectors, whose quotient is dropped
		den = (mag_sq == '0) ? (PW/2)'(1) : mag_sq;
	end

	logic vx, vy, vz;
	logic signed [NW:0] qx, qy, qz;

	v3au_div #(.NUM_W(NW), .DEN_W(PW/2), .tag_t(dtag_t)) u_div_x (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_sq), .in_num(cr_sq.nx),
		.in_den(den), .in_tag(dt_in), .out_vld(vx), .out_quo(qx), .out_tag(dx_t)
	);
	v3au_div #(.NUM_W(NW), .DEN_W(PW/2), .tag_t(dtag_t)) u_div_y (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_sq), .in_num(cr_sq.ny),
		.in_den(den), .in_tag(dt_in), .out_vld(vy), .out_quo(qy), .out_tag(dy_t)
	);
	v3au_div #(.NUM_W(NW), .DEN_W(PW/2), .tag_t(dtag_t)) u_div_z (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_sq), .in_num(cr_sq.nz),
		.in_den(den), .in_tag(dt_in), .out_vld(vz), .out_quo(qz), .out_tag(dz_t)
	);

	// ---- output register ----
	v3au_pkg::item_out_t res;
	logic [32:0] ux, uy, uz;
	always_comb begin
		ux = v3au_pkg::sat32(66'(qx));
		uy = v3au_pkg::sat32(66'(qy));
		uz = v3au_pkg::sat32(66'(qz));
		res.r_x        = dx_t.cr.rx;
		res.r_y        = dx_t.cr.ry;
		res.r_z        = dx_t.cr.rz;
		res.scalar_out = dx_t.cr.sc;
		res.is_null    = 1'b0;
		res.overflow   = dx_t.cr.ov;
		case (dx_t.cr.op)
			v3au_pkg::OP_MAG: res.is_null = dx_t.nul;
			v3au_pkg::OP_UNIT: begin
				res.is_null = dx_t.nul;
				if (!dx_t.nul) begin
					res.r_x      = ux[31:0];
					res.r_y      = uy[31:0];
					res.r_z      = uz[31:0];
					res.overflow = ux[32] | uy[32] | uz[32];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vx & vy & vz;
	end

	always_ff @(posedge clk) begin
		out_item <= res;
	end

	// tags of the y and z dividers match x; only their valid bits are used
	logic unused_tags;
	assign unused_tags = ^{dy_t, dz_t};
endmodule

### rtl/v3au_sqrt.sv
// ----------------------------------------------------------------------------
// v3au_sqrt
// pipelined restoring integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module v3au_sqrt #(
	parameter int IN_W = 66,
	parameter type tag_t = logic
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [IN_W-1:0]     in_rad,
	input  tag_t                in_tag,
	output logic                out_vld,
	output logic [IN_W/2-1:0]   out_root,
	output tag_t                out_tag
);
	localparam int N = IN_W / 2;

	logic [N:0]       vld_s;
	logic [IN_W-1:0]  rad_s  [N+1];
	logic [N+1:0]     rem_s  [N+1];
	logic [N-1:0]     root_s [N+1];
	tag_t             tag_s  [N+1];

	always_comb begin
		vld_s[0]  = in_vld;
		rad_s[0]  = in_rad;
		rem_s[0]  = '0;
		root_s[0] = '0;
		tag_s[0]  = in_tag;
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N+1:0] trial;
		logic [N+1:0] rem_sh;
		always_comb begin
			rem_sh = {rem_s[k][N-1:0], rad_s[k][IN_W-1 -: 2]};
			trial  = {root_s[k], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vld_s[k];
		end
		always_ff @(posedge clk) begin
			rad_s[k+1] <= {rad_s[k][IN_W-3:0], 2'b00};
			tag_s[k+1] <= tag_s[k];
			if (rem_sh >= trial) begin
				rem_s[k+1]  <= rem_sh - trial;
				root_s[k+1] <= {root_s[k][N-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= rem_sh;
				root_s[k+1] <= {root_s[k][N-2:0], 1'b0};
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_root = root_s[N];
	assign out_tag  = tag_s[N];
endmodule

### rtl/v3au_div.sv
// ----------------------------------------------------------------------------
// v3au_div
// pipelined restoring divider, signed dividend by unsigned divisor, one bit
// per stage, quotient truncated toward zero
// ----------------------------------------------------------------------------
module v3au_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 33,
	parameter type tag_t = logic
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	input  logic signed [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0]        in_den,
	input  tag_t                    in_tag,
	output logic                    out_vld,
	output logic signed [NUM_W:0]   out_quo,
	output tag_t                    out_tag
);
	logic [NUM_W:0]   vld_s;
	logic [NUM_W-1:0] mag_s [NUM_W+1];
	logic [DEN_W:0]   rem_s [NUM_W+1];
	logic [DEN_W-1:0] den_s [NUM_W+1];
	logic             neg_s [NUM_W+1];
	tag_t             tag_s [NUM_W+1];

	always_comb begin
		vld_s[0] = in_vld;
		neg_s[0] = in_num[NUM_W-1];
		mag_s[0] = in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
		rem_s[0] = '0;
		den_s[0] = in_den;
		tag_s[0] = in_tag;
	end

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [DEN_W:0] sh;
		always_comb sh = {rem_s[k][DEN_W-1:0], mag_s[k][NUM_W-1]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vld_s[k];
		end
		always_ff @(posedge clk) begin
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			tag_s[k+1] <= tag_s[k];
			if (sh >= {1'b0, den_s[k]}) begin
				rem_s[k+1] <= sh - {1'b0, den_s[k]};
				mag_s[k+1] <= {mag_s[k][NUM_W-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= sh;
				mag_s[k+1] <= {mag_s[k][NUM_W-2:0], 1'b0};
			end
		end
	end

	// the magnitude of -2^(NUM_W-1) is still exact as an unsigned value
	logic [NUM_W:0] qmag;
	always_comb begin
		qmag = {1'b0, mag_s[NUM_W]};
		out_quo = neg_s[NUM_W] ? -$signed(qmag) : $signed(qmag);
	end
	assign out_vld = vld_s[NUM_W];
	assign out_tag = tag_s[NUM_W];
endmodule
